// ----- src/matrix_inverse_3x3_assert.svh -----
// Assertion macros shared by the matrix inverse RTL.
// Plain header, no dependencies; included by the files that check their own logic.
`ifndef MATRIX_INVERSE_3X3_ASSERT_SVH
`define MATRIX_INVERSE_3X3_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define MI3_ASSERT_IMP(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define MI3_ASSERT_NXT(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/mi3_pkg.sv -----
// Shared types, widths and helpers for the 3x3 matrix inverse.
// No dependencies; used by the lanes, the merge stage and the top level.
package mi3_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int ELEM_WIDTH = 32;
  localparam int IO_W       = 32;
  localparam int VAL_W      = (ELEM_WIDTH < 32) ? ELEM_WIDTH : 32;
  localparam int MUL_W      = VAL_W + 1;
  localparam int PROD_W     = 2 * MUL_W;
  localparam int COF_W      = 2 * VAL_W + 1;
  localparam int DET_W      = 3 * VAL_W + 2;
  localparam int QUO_W      = VAL_W;
  localparam int NUM_W      = COF_W + 2 * FRAC_BITS;
  localparam int WIDE_W     = ((NUM_W > DET_W + QUO_W) ? NUM_W : DET_W + QUO_W) + 1;
  localparam int CNT_W      = $clog2(QUO_W);

  localparam logic [QUO_W:0] POS_LIM = (QUO_W+1)'((64'd1 << (VAL_W - 1)) - 64'd1);
  localparam logic [QUO_W:0] NEG_LIM = (QUO_W+1)'(64'd1 << (VAL_W - 1));

  typedef enum logic [2:0] {
    LOP_IDLE,
    LOP_COF0,
    LOP_COF1,
    LOP_DET_LO,
    LOP_DET_HI,
    LOP_DIV_INIT,
    LOP_DIV_STEP,
    LOP_DIV_ROUND
  } lane_op_t;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_COF,
    ST_DRAIN,
    ST_SUM,
    ST_ABS,
    ST_DIV_INIT,
    ST_DIV_STEP,
    ST_DIV_ROUND,
    ST_OUT
  } state_t;

  typedef struct packed {
    lane_op_t   op;
    logic [1:0] row;
  } lane_ctrl_t;

  typedef struct packed {
    logic signed [IO_W-1:0] in_col0;
    logic signed [IO_W-1:0] in_col1;
    logic signed [IO_W-1:0] in_col2;
  } in_row_t;

  typedef struct packed {
    logic signed [IO_W-1:0] out_col0;
    logic signed [IO_W-1:0] out_col1;
    logic signed [IO_W-1:0] out_col2;
    logic        [1:0]      out_row;
    logic signed [IO_W-1:0] det_value;
    logic                   singular;
    logic                   overflow;
    logic                   last_row;
  } out_row_t;

  // Sign-extends a stored element to the multiplier operand width.
  function automatic logic signed [MUL_W-1:0] elem_ext(input logic [VAL_W-1:0] v);
    return MUL_W'(signed'(v));
  endfunction

endpackage

// ----- src/mi3_lane.sv -----
// One lane of the inverse: a shared signed multiplier for cofactors and the
// determinant partial, and a restoring divider for one inverse row. Uses mi3_pkg.
module mi3_lane (
  input  logic                                  clk,
  input  logic                                  rst,
  input  mi3_pkg::lane_ctrl_t                   ctrl,
  input  logic signed [mi3_pkg::MUL_W-1:0]      mul_a,
  input  logic signed [mi3_pkg::MUL_W-1:0]      mul_b,
  input  logic        [mi3_pkg::DET_W-1:0]      det_abs,
  input  logic                                  det_neg,
  output logic signed [mi3_pkg::DET_W-1:0]      pdet,
  output logic [2:0][mi3_pkg::IO_W-1:0]         inv,
  output logic                                  ovf
);

  localparam int VW = mi3_pkg::VAL_W;
  localparam int MW = mi3_pkg::MUL_W;
  localparam int PW = mi3_pkg::PROD_W;
  localparam int CW = mi3_pkg::COF_W;
  localparam int DW = mi3_pkg::DET_W;
  localparam int QW = mi3_pkg::QUO_W;
  localparam int WW = mi3_pkg::WIDE_W;

  logic signed [MW-1:0] mb;
  logic signed [PW-1:0] prod_q;
  mi3_pkg::lane_op_t    op_q;
  logic [1:0]           row_q;
  logic signed [CW-1:0] cof_acc;
  logic signed [CW-1:0] cof [3];

  logic [DW-1:0] rem;
  logic [QW-1:0] numl;
  logic [QW-1:0] quo;
  logic          dsat;
  logic          dneg;

  logic signed [CW-1:0] sel_cof;
  logic [CW-1:0]        cof_mag;
  logic [WW-1:0]        num_wide;
  logic [WW-1:0]        den_wide;
  logic [DW:0]          trial;
  logic [DW:0]          den_ext;
  logic [DW:0]          diff;
  logic                 take;
  logic                 half_up;
  logic [QW:0]          mag;
  logic [QW:0]          lim;
  logic                 clip;
  logic [QW:0]          mag_sat;
  logic signed [63:0]   mag64;
  logic signed [63:0]   res64;

  // The determinant partial reuses the multiplier on the low and high halves of cof[0].
  always_comb begin
    unique case (ctrl.op)
      mi3_pkg::LOP_DET_LO: mb = signed'({1'b0, cof[0][VW-1:0]});
      mi3_pkg::LOP_DET_HI: mb = signed'(cof[0][CW-1:VW]);
      default:             mb = mul_b;
    endcase
  end

  always_ff @(posedge clk) begin
    prod_q <= mul_a * mb;
    row_q  <= ctrl.row;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      op_q <= mi3_pkg::LOP_IDLE;
    end else begin
      op_q <= ctrl.op;
    end
  end

  always_ff @(posedge clk) begin
    unique case (op_q)
      mi3_pkg::LOP_COF0:   cof_acc <= CW'(prod_q);
      mi3_pkg::LOP_COF1:   cof[row_q] <= cof_acc - CW'(prod_q);
      mi3_pkg::LOP_DET_LO: pdet <= DW'(prod_q);
      mi3_pkg::LOP_DET_HI: pdet <= pdet + (DW'(prod_q) <<< VW);
      default: ;
    endcase
  end

  always_comb begin
    sel_cof  = cof[ctrl.row];
    cof_mag  = sel_cof[CW-1] ? CW'(-sel_cof) : CW'(sel_cof);
    num_wide = WW'(cof_mag) << (2 * mi3_pkg::FRAC_BITS);
    den_wide = WW'(det_abs) << QW;
    trial    = {rem, numl[QW-1]};
    den_ext  = {1'b0, det_abs};
    take     = trial >= den_ext;
    diff     = trial - den_ext;
    half_up  = {rem, 1'b0} >= den_ext;
    mag      = {1'b0, quo} + (QW+1)'(half_up);
    lim      = dneg ? mi3_pkg::NEG_LIM : mi3_pkg::POS_LIM;
    clip     = dsat || (mag > lim);
    mag_sat  = clip ? lim : mag;
    mag64    = signed'(64'(mag_sat));
    res64    = dneg ? -mag64 : mag64;
  end

  // A quotient that would reach 2^QW is flagged at init, so only QW steps are run.
  always_ff @(posedge clk) begin
    unique case (ctrl.op)
      mi3_pkg::LOP_DIV_INIT: begin
        rem  <= DW'(num_wide >> QW);
        numl <= num_wide[QW-1:0];
        quo  <= '0;
        dsat <= num_wide >= den_wide;
        dneg <= sel_cof[CW-1] ^ det_neg;
      end
      mi3_pkg::LOP_DIV_STEP: begin
        numl <= {numl[QW-2:0], 1'b0};
        quo  <= {quo[QW-2:0], take};
        rem  <= take ? diff[DW-1:0] : trial[DW-1:0];
      end
      mi3_pkg::LOP_DIV_ROUND: inv[ctrl.row] <= res64[mi3_pkg::IO_W-1:0];
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ovf <= 1'b0;
    end else if (op_q == mi3_pkg::LOP_COF0) begin
      ovf <= 1'b0;
    end else if (ctrl.op == mi3_pkg::LOP_DIV_ROUND && clip) begin
      ovf <= 1'b1;
    end
  end

endmodule

// ----- src/mi3_merge.sv -----
// Merge stage: sums the lane determinant partials, rounds the determinant,
// and assembles one result row from the lanes. Uses mi3_pkg.
module mi3_merge (
  input  logic                                   clk,
  input  logic                                   sum_en,
  input  logic [2:0][mi3_pkg::DET_W-1:0]         pdet,
  input  logic [2:0][2:0][mi3_pkg::IO_W-1:0]     lane_inv,
  input  logic [2:0]                             lane_ovf,
  input  logic [1:0]                             row_sel,
  output logic [mi3_pkg::DET_W-1:0]              det_abs,
  output logic                                   det_neg,
  output logic                                   singular,
  output mi3_pkg::out_row_t                      result
);

  localparam int DW = mi3_pkg::DET_W;
  localparam int QW = mi3_pkg::QUO_W;
  localparam int F2 = 2 * mi3_pkg::FRAC_BITS;

  logic signed [DW-1:0] det;
  logic [DW:0]          dmag;
  logic [DW:0]          dlim;
  logic                 dclip;
  logic [QW:0]          dmag_sat;
  logic signed [63:0]   d64;
  logic signed [63:0]   dres;
  logic [mi3_pkg::IO_W-1:0] detq;
  logic                 det_ovf;
  logic [2:0][mi3_pkg::IO_W-1:0] picked;

  always_ff @(posedge clk) begin
    if (sum_en) begin
      det <= signed'(pdet[0]) + signed'(pdet[1]) + signed'(pdet[2]);
    end
  end

  // The sequencer decides on the zero determinant in the cycle right after the sum.
  assign singular = det == '0;

  always_ff @(posedge clk) begin
    det_abs  <= det[DW-1] ? DW'(-det) : DW'(det);
    det_neg  <= det[DW-1];
  end

  // Round to nearest, ties away from zero, on the magnitude.
  always_comb begin
    dmag     = (DW+1)'(det_abs >> F2) + (DW+1)'(det_abs[F2-1]);
    dlim     = (DW+1)'(det_neg ? mi3_pkg::NEG_LIM : mi3_pkg::POS_LIM);
    dclip    = dmag > dlim;
    dmag_sat = dclip ? (QW+1)'(dlim) : dmag[QW:0];
    d64      = signed'(64'(dmag_sat));
    dres     = det_neg ? -d64 : d64;
  end

  always_ff @(posedge clk) begin
    detq    <= dres[mi3_pkg::IO_W-1:0];
    det_ovf <= dclip;
  end

  always_comb begin
    case (row_sel)
      2'd0:    picked = lane_inv[0];
      2'd1:    picked = lane_inv[1];
      default: picked = lane_inv[2];
    endcase
    result.out_col0  = singular ? '0 : signed'(picked[0]);
    result.out_col1  = singular ? '0 : signed'(picked[1]);
    result.out_col2  = singular ? '0 : signed'(picked[2]);
    result.out_row   = row_sel;
    result.det_value = singular ? '0 : signed'(detq);
    result.singular  = singular;
    result.overflow  = !singular && (det_ovf || (lane_ovf != '0));
    result.last_row  = row_sel == 2'd2;
  end

endmodule

// ----- src/matrix_inverse_3x3.sv -----
// Top level of the 3x3 matrix inverse: row store, sequencer, three lanes and merge.
// Depends on mi3_pkg, mi3_lane, mi3_merge and matrix_inverse_3x3_assert.svh.
//
// A matrix is loaded one row per beat, and the third row starts the computation.
// Busy then stays high while the lanes run the cofactor and determinant multiplies,
// the determinant is summed and rounded and, unless it is zero, three division
// rounds follow, each run by the 32-step restoring divider in every lane producing
// one quotient bit per cycle; finally three result beats come on consecutive cycles.
// Results are registered and show up in the cycle after the sequencer issues them;
// the receiver cannot stall, so each beat is present for one cycle only, marked
// by strobe.
`include "matrix_inverse_3x3_assert.svh"

module matrix_inverse_3x3 (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  mi3_pkg::in_row_t    data,
  output logic                busy,
  output logic                strobe,
  output mi3_pkg::out_row_t   result
);

  localparam int VW  = mi3_pkg::VAL_W;
  localparam int MW  = mi3_pkg::MUL_W;
  localparam int CNW = mi3_pkg::CNT_W;
  localparam logic [CNW-1:0] CNT_COF_LAST = CNW'(7);
  localparam logic [CNW-1:0] CNT_DET_LO   = CNW'(6);
  localparam logic [CNW-1:0] CNT_DIV_LAST = CNW'(mi3_pkg::QUO_W - 1);
  localparam logic [CNW-1:0] CNT_OUT_LAST = CNW'(2);

  mi3_pkg::state_t    state;
  mi3_pkg::state_t    state_next;
  logic [CNW-1:0]     cnt;
  logic [1:0]         drow;
  logic [1:0]         row_count;
  logic [2:0][2:0][VW-1:0] mat;
  logic               accept;

  mi3_pkg::lane_ctrl_t ctrl;
  logic                sum_en;
  logic signed [MW-1:0] mul_a [3];
  logic signed [MW-1:0] mul_b [3];
  logic [2:0][mi3_pkg::DET_W-1:0]     pdet;
  logic [2:0][2:0][mi3_pkg::IO_W-1:0] lane_inv;
  logic [2:0]                         lane_ovf;
  logic [mi3_pkg::DET_W-1:0]          det_abs;
  logic                               det_neg;
  logic                               singular;
  mi3_pkg::out_row_t                  merged;

  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= 2'd0;
    end else if (accept) begin
      row_count <= (row_count == 2'd1) ? 2'd2 : (row_count == 2'd0) ? 2'd1 : 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      case (row_count)
        2'd1:    mat[1] <= {data.in_col2[VW-1:0], data.in_col1[VW-1:0], data.in_col0[VW-1:0]};
        2'd2:    mat[2] <= {data.in_col2[VW-1:0], data.in_col1[VW-1:0], data.in_col0[VW-1:0]};
        default: mat[0] <= {data.in_col2[VW-1:0], data.in_col1[VW-1:0], data.in_col0[VW-1:0]};
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mi3_pkg::ST_LOAD;
      cnt   <= '0;
      drow  <= 2'd0;
    end else begin
      state <= state_next;
      cnt   <= (state != state_next) ? '0 : cnt + CNW'(1);
      if (state == mi3_pkg::ST_ABS) begin
        drow <= 2'd0;
      end else if (state == mi3_pkg::ST_DIV_ROUND) begin
        drow <= drow + 2'd1;
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      mi3_pkg::ST_LOAD:      if (accept && row_count == 2'd2) state_next = mi3_pkg::ST_COF;
      mi3_pkg::ST_COF:       if (cnt == CNT_COF_LAST) state_next = mi3_pkg::ST_DRAIN;
      mi3_pkg::ST_DRAIN:     state_next = mi3_pkg::ST_SUM;
      mi3_pkg::ST_SUM:       state_next = mi3_pkg::ST_ABS;
      mi3_pkg::ST_ABS:       state_next = singular ? mi3_pkg::ST_OUT : mi3_pkg::ST_DIV_INIT;
      mi3_pkg::ST_DIV_INIT:  state_next = mi3_pkg::ST_DIV_STEP;
      mi3_pkg::ST_DIV_STEP:  if (cnt == CNT_DIV_LAST) state_next = mi3_pkg::ST_DIV_ROUND;
      mi3_pkg::ST_DIV_ROUND: state_next = (drow == 2'd2) ? mi3_pkg::ST_OUT
                                                         : mi3_pkg::ST_DIV_INIT;
      mi3_pkg::ST_OUT:       if (cnt == CNT_OUT_LAST) state_next = mi3_pkg::ST_LOAD;
      default:               state_next = mi3_pkg::ST_LOAD;
    endcase
  end

  always_comb begin
    ctrl.op  = mi3_pkg::LOP_IDLE;
    ctrl.row = 2'd0;
    busy     = state != mi3_pkg::ST_LOAD;
    sum_en   = state == mi3_pkg::ST_SUM;
    unique case (state)
      mi3_pkg::ST_COF: begin
        if (cnt == CNT_DET_LO) begin
          ctrl.op = mi3_pkg::LOP_DET_LO;
        end else if (cnt == CNT_COF_LAST) begin
          ctrl.op = mi3_pkg::LOP_DET_HI;
        end else begin
          ctrl.op  = cnt[0] ? mi3_pkg::LOP_COF1 : mi3_pkg::LOP_COF0;
          ctrl.row = cnt[2:1];
        end
      end
      mi3_pkg::ST_DIV_INIT: begin
        ctrl.op  = mi3_pkg::LOP_DIV_INIT;
        ctrl.row = drow;
      end
      mi3_pkg::ST_DIV_STEP: ctrl.op = mi3_pkg::LOP_DIV_STEP;
      mi3_pkg::ST_DIV_ROUND: begin
        ctrl.op  = mi3_pkg::LOP_DIV_ROUND;
        ctrl.row = drow;
      end
      default: ;
    endcase
  end

  // Lane k works on cofactor column k, which after division is inverse row k.
  for (genvar k = 0; k < 3; k++) begin : g_lane
    localparam int C1 = (k + 1) % 3;
    localparam int C2 = (k + 2) % 3;
    logic [VW-1:0] e_p, e_q, e_s, e_t;

    always_comb begin
      case (ctrl.row)
        2'd0: begin
          e_p = mat[1][C1]; e_q = mat[2][C2]; e_s = mat[1][C2]; e_t = mat[2][C1];
        end
        2'd1: begin
          e_p = mat[2][C1]; e_q = mat[0][C2]; e_s = mat[2][C2]; e_t = mat[0][C1];
        end
        default: begin
          e_p = mat[0][C1]; e_q = mat[1][C2]; e_s = mat[0][C2]; e_t = mat[1][C1];
        end
      endcase
      case (ctrl.op)
        mi3_pkg::LOP_COF1: begin
          mul_a[k] = mi3_pkg::elem_ext(e_s);
          mul_b[k] = mi3_pkg::elem_ext(e_t);
        end
        mi3_pkg::LOP_DET_LO, mi3_pkg::LOP_DET_HI: begin
          mul_a[k] = mi3_pkg::elem_ext(mat[0][k]);
          mul_b[k] = '0;
        end
        default: begin
          mul_a[k] = mi3_pkg::elem_ext(e_p);
          mul_b[k] = mi3_pkg::elem_ext(e_q);
        end
      endcase
    end

    mi3_lane u_lane (
      .clk     (clk),
      .rst     (rst),
      .ctrl    (ctrl),
      .mul_a   (mul_a[k]),
      .mul_b   (mul_b[k]),
      .det_abs (det_abs),
      .det_neg (det_neg),
      .pdet    (pdet[k]),
      .inv     (lane_inv[k]),
      .ovf     (lane_ovf[k])
    );
  end

  mi3_merge u_merge (
    .clk      (clk),
    .sum_en   (sum_en),
    .pdet     (pdet),
    .lane_inv (lane_inv),
    .lane_ovf (lane_ovf),
    .row_sel  (cnt[1:0]),
    .det_abs  (det_abs),
    .det_neg  (det_neg),
    .singular (singular),
    .result   (merged)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= state == mi3_pkg::ST_OUT;
    end
  end

  always_ff @(posedge clk) begin
    if (state == mi3_pkg::ST_OUT) begin
      result <= merged;
    end
  end

  `MI3_ASSERT_IMP(a_row_range, clk, rst, strobe, result.out_row != 2'd3, "result row index out of range")
  `MI3_ASSERT_IMP(a_sing_zero, clk, rst, strobe && result.singular, result.det_value == 0 && !result.overflow && result.out_col0 == 0, "singular beat carries nonzero data")
  `MI3_ASSERT_NXT(a_busy_third, clk, rst, accept && row_count == 2'd2, busy, "third row did not start the computation")
  `MI3_ASSERT_NXT(a_out_burst, clk, rst, strobe && !result.last_row, strobe && result.out_row == $past(result.out_row) + 2'd1, "result beats not consecutive")

endmodule
